// ===== sv/frame_bitmap_region_marker_macros.svh =====
// Assertion macros shared by the frame bitmap region marker RTL.
`ifndef FRAME_BITMAP_REGION_MARKER_MACROS_SVH
`define FRAME_BITMAP_REGION_MARKER_MACROS_SVH

// Same-cycle implication, held off during reset
`define FBRM_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off during reset
`define FBRM_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/fbrm_pkg.sv =====
// Shared types, codes and constants for the frame bitmap region marker.
`timescale 1ns / 1ps
`default_nettype none
package fbrm_pkg;

    localparam int MAX_FRAMES_DEF = 65536;

    localparam int ADDR_W      = 32;
    localparam int COUNT_W     = 17;
    localparam int OP_W        = 2;
    localparam int PAGE_SHIFT  = 12;
    // frame number from a 32-bit address, plus one bit to hold the frame limit
    localparam int FRAME_NUM_W = ADDR_W - PAGE_SHIFT + 1;
    localparam int WORD_W      = 8;
    localparam int BIT_IDX_W   = 3;
    localparam int WORD_IDX_W  = FRAME_NUM_W - BIT_IDX_W;

    localparam logic [ADDR_W-1:0]  PAGE_MASK = 32'h0000_0FFF;
    localparam logic [WORD_W-1:0]  WORD_FULL = 8'hFF;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 17'h1FFFF;

    // Input opcodes
    localparam logic [OP_W-1:0] OP_RESET     = 2'd0;
    localparam logic [OP_W-1:0] OP_MARK_USED = 2'd1;
    localparam logic [OP_W-1:0] OP_MARK_FREE = 2'd2;

    // Command kinds handed from front to back
    typedef logic [1:0] t_cmd_kind;
    localparam t_cmd_kind CMD_NOP  = 2'd0;
    localparam t_cmd_kind CMD_FILL = 2'd1;
    localparam t_cmd_kind CMD_SET  = 2'd2;
    localparam t_cmd_kind CMD_CLR  = 2'd3;

    typedef struct packed {
        t_cmd_kind              kind;
        logic [WORD_IDX_W-1:0]  first_word;
        logic [WORD_IDX_W-1:0]  last_word;
        logic [BIT_IDX_W-1:0]   lo_bit;
        logic [BIT_IDX_W-1:0]   hi_bit;
        logic [COUNT_W-1:0]     lim;
    } t_cmd;

endpackage
`default_nettype wire

// ===== sv/fbrm_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
`default_nettype none
module fbrm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ===== sv/fbrm_front.sv =====
// Front end: aligns the byte region and turns an operation into a word-range command.
`timescale 1ns / 1ps
`default_nettype none
module fbrm_front #(
    parameter int MAX_FRAMES = fbrm_pkg::MAX_FRAMES_DEF
) (
    input  wire logic [fbrm_pkg::OP_W-1:0]    i_opcode,
    input  wire logic [fbrm_pkg::ADDR_W-1:0]  i_start_address,
    input  wire logic [fbrm_pkg::ADDR_W-1:0]  i_region_length,
    input  wire logic [fbrm_pkg::COUNT_W-1:0] i_total_frame_count,
    output fbrm_pkg::t_cmd                    o_cmd
);
    import fbrm_pkg::*;

    localparam logic [FRAME_NUM_W-1:0] MaxFr = FRAME_NUM_W'(MAX_FRAMES);

    logic [ADDR_W-1:0]      end_byte;
    logic [ADDR_W-1:0]      rs_used, re_used, rs_free, re_free;
    logic [FRAME_NUM_W-1:0] first_fr, last_fr, total_fr, lim_fr, stop_fr, stop_m1;
    logic                   walk;

    // Align region ends; the end address wraps modulo 2^32
    assign end_byte = i_start_address + i_region_length;
    assign rs_used  = i_start_address & ~PAGE_MASK;
    assign re_used  = (end_byte + PAGE_MASK) & ~PAGE_MASK;
    assign rs_free  = (i_start_address + PAGE_MASK) & ~PAGE_MASK;
    assign re_free  = end_byte & ~PAGE_MASK;

    // Pick frame bounds for the operation
    always_comb begin
        if (i_opcode == OP_MARK_FREE) begin
            first_fr = {1'b0, rs_free[ADDR_W-1:PAGE_SHIFT]};
            last_fr  = {1'b0, re_free[ADDR_W-1:PAGE_SHIFT]};
        end else begin
            first_fr = {1'b0, rs_used[ADDR_W-1:PAGE_SHIFT]};
            last_fr  = {1'b0, re_used[ADDR_W-1:PAGE_SHIFT]};
        end
    end

    // Clamp to the managed frame count
    assign total_fr = FRAME_NUM_W'(i_total_frame_count);
    assign lim_fr   = (total_fr > MaxFr) ? MaxFr : total_fr;
    assign stop_fr  = (last_fr < lim_fr) ? last_fr : lim_fr;
    assign walk     = first_fr < stop_fr;
    assign stop_m1  = stop_fr - FRAME_NUM_W'(1);

    // Build the command
    always_comb begin
        o_cmd.first_word = first_fr[FRAME_NUM_W-1:BIT_IDX_W];
        o_cmd.last_word  = stop_m1[FRAME_NUM_W-1:BIT_IDX_W];
        o_cmd.lo_bit     = first_fr[BIT_IDX_W-1:0];
        o_cmd.hi_bit     = stop_m1[BIT_IDX_W-1:0];
        o_cmd.lim        = lim_fr[COUNT_W-1:0];
        unique case (i_opcode)
            OP_RESET:     o_cmd.kind = CMD_FILL;
            OP_MARK_USED: o_cmd.kind = walk ? CMD_SET : CMD_NOP;
            OP_MARK_FREE: o_cmd.kind = walk ? CMD_CLR : CMD_NOP;
            default:      o_cmd.kind = CMD_NOP;
        endcase
    end

endmodule
`default_nettype wire

// ===== sv/fbrm_queue.sv =====
// Two-entry command queue between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none
module fbrm_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire fbrm_pkg::t_cmd i_cmd,
    input  wire logic           i_pop,
    output logic                o_full,
    output logic                o_valid,
    output fbrm_pkg::t_cmd      o_cmd
);
    import fbrm_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wptr, r_rptr;
    logic [1:0] r_count;
    logic [1:0] n_count;

    assign o_full  = r_count == 2'd2;
    assign o_valid = r_count != 2'd0;
    assign o_cmd   = r_mem[r_rptr];

    // Track fill level
    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 2'd1;
        end
    end

    // Advance pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

endmodule
`default_nettype wire

// ===== sv/fbrm_back.sv =====
// Back end: walks the frame map word by word, keeps the counters, holds the result.
`timescale 1ns / 1ps
`default_nettype none
`include "frame_bitmap_region_marker_macros.svh"
module fbrm_back #(
    parameter int MAX_FRAMES = fbrm_pkg::MAX_FRAMES_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cmd_valid,
    input  wire fbrm_pkg::t_cmd               i_cmd,
    output logic                              o_cmd_pop,
    output logic                              o_init_busy,
    input  wire logic                         i_out_stall,
    output logic                              o_out_valid,
    output logic [fbrm_pkg::COUNT_W-1:0]      o_free_count,
    output logic [fbrm_pkg::COUNT_W-1:0]      o_used_count
);
    import fbrm_pkg::*;

    localparam int DEPTH = (MAX_FRAMES + WORD_W - 1) / WORD_W;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW-1:0]      LastAddr  = AW'(DEPTH - 1);
    localparam logic [COUNT_W-1:0] ResetUsed =
        COUNT_W'((MAX_FRAMES > 65536) ? 65536 : MAX_FRAMES);

    localparam logic [2:0] S_SWEEP = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_WALK  = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    function automatic logic [BIT_IDX_W:0] pop8(input logic [WORD_W-1:0] v);
        logic [BIT_IDX_W:0] s;
        s = '0;
        for (int k = 0; k < WORD_W; k++) begin
            s = s + (BIT_IDX_W+1)'(v[k]);
        end
        return s;
    endfunction

    function automatic logic [COUNT_W-1:0] sat_add(input logic [COUNT_W-1:0] v,
                                                   input logic [BIT_IDX_W:0] n);
        logic [COUNT_W:0] s;
        s = {1'b0, v} + (COUNT_W+1)'(n);
        return (s >= {1'b0, COUNT_MAX}) ? COUNT_MAX : s[COUNT_W-1:0];
    endfunction

    function automatic logic [COUNT_W-1:0] floor_sub(input logic [COUNT_W-1:0] v,
                                                     input logic [BIT_IDX_W:0] n);
        return (v > COUNT_W'(n)) ? (v - COUNT_W'(n)) : '0;
    endfunction

    logic [2:0]            r_state, n_state;
    logic                  r_init, n_init;
    logic [AW-1:0]         r_addr, n_addr;
    logic [COUNT_W-1:0]    r_used, n_used, r_free, n_free;
    logic                  r_p_valid, n_p_valid;
    logic                  r_out_valid, n_out_valid;
    logic [AW-1:0]         r_last, n_last;
    logic [BIT_IDX_W-1:0]  r_lo, n_lo, r_hi, n_hi;
    logic                  r_set, n_set;
    logic                  r_first, n_first;
    logic [AW-1:0]         r_p_addr;
    logic [WORD_W-1:0]     r_p_mask;
    logic [COUNT_W-1:0]    r_out_free, r_out_used;

    logic [WORD_W-1:0]     rd_data, new_word, issue_mask;
    logic [BIT_IDX_W-1:0]  lo_e, hi_e;
    logic [BIT_IDX_W:0]    n_chg;
    logic                  ram_we, out_load;
    logic [AW-1:0]         ram_waddr;
    logic [WORD_W-1:0]     ram_wdata;

    assign o_init_busy  = r_init;
    assign o_out_valid  = r_out_valid;
    assign o_free_count = r_out_free;
    assign o_used_count = r_out_used;
    assign o_cmd_pop    = (r_state == S_IDLE) && i_cmd_valid;
    assign out_load     = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);

    // Bit mask of the word being issued
    assign lo_e = r_first ? r_lo : '0;
    assign hi_e = (r_addr == r_last) ? r_hi : '1;
    always_comb begin
        for (int b = 0; b < WORD_W; b++) begin
            issue_mask[b] = (BIT_IDX_W'(b) >= lo_e) && (BIT_IDX_W'(b) <= hi_e);
        end
    end

    // Modify the word read back last cycle
    assign new_word = r_set ? (rd_data | r_p_mask) : (rd_data & ~r_p_mask);
    assign n_chg    = pop8(rd_data ^ new_word);

    // Map write port: fill sweep or read-modify-write
    always_comb begin
        if (r_state == S_SWEEP) begin
            ram_we    = 1'b1;
            ram_waddr = r_addr;
            ram_wdata = WORD_FULL;
        end else begin
            ram_we    = r_p_valid;
            ram_waddr = r_p_addr;
            ram_wdata = new_word;
        end
    end

    fbrm_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_addr),
        .o_rdata (rd_data)
    );

    // Sequencer and counters
    always_comb begin
        n_state     = r_state;
        n_init      = r_init;
        n_addr      = r_addr;
        n_used      = r_used;
        n_free      = r_free;
        n_p_valid   = 1'b0;
        n_last      = r_last;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_set       = r_set;
        n_first     = r_first;
        n_out_valid = r_out_valid && i_out_stall;

        if (r_p_valid) begin
            if (r_set) begin
                n_used = sat_add(r_used, n_chg);
                n_free = floor_sub(r_free, n_chg);
            end else begin
                n_free = sat_add(r_free, n_chg);
                n_used = floor_sub(r_used, n_chg);
            end
        end

        unique case (r_state)
            S_SWEEP: begin
                if (r_addr == LastAddr) begin
                    n_state = r_init ? S_IDLE : S_DONE;
                    n_init  = 1'b0;
                end else begin
                    n_addr = r_addr + AW'(1);
                end
            end
            S_IDLE: begin
                if (i_cmd_valid) begin
                    unique case (i_cmd.kind)
                        CMD_FILL: begin
                            n_used  = i_cmd.lim;
                            n_free  = '0;
                            n_addr  = '0;
                            n_state = S_SWEEP;
                        end
                        CMD_SET, CMD_CLR: begin
                            n_addr  = i_cmd.first_word[AW-1:0];
                            n_last  = i_cmd.last_word[AW-1:0];
                            n_lo    = i_cmd.lo_bit;
                            n_hi    = i_cmd.hi_bit;
                            n_set   = i_cmd.kind == CMD_SET;
                            n_first = 1'b1;
                            n_state = S_WALK;
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_WALK: begin
                n_p_valid = 1'b1;
                n_first   = 1'b0;
                if (r_addr == r_last) begin
                    n_state = S_DRAIN;
                end else begin
                    n_addr = r_addr + AW'(1);
                end
            end
            S_DRAIN: n_state = S_DONE;
            S_DONE: begin
                if (out_load) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_SWEEP;
            r_init      <= 1'b1;
            r_addr      <= '0;
            r_used      <= ResetUsed;
            r_free      <= '0;
            r_p_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_init      <= n_init;
            r_addr      <= n_addr;
            r_used      <= n_used;
            r_free      <= n_free;
            r_p_valid   <= n_p_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_last   <= n_last;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_set    <= n_set;
        r_first  <= n_first;
        r_p_addr <= r_addr;
        r_p_mask <= issue_mask;
        if (out_load) begin
            r_out_free <= r_free;
            r_out_used <= r_used;
        end
    end

    `FBRM_ASSERT_IMP(a_pend_from_walk, i_clk, i_rst_n, r_p_valid, $past(r_state) == S_WALK, "pending word without a walk issue")
    `FBRM_ASSERT_IMP(a_done_drained, i_clk, i_rst_n, r_state == S_DONE, !r_p_valid, "result taken before last word was written")
    `FBRM_ASSERT_NXT(a_pop_leaves_idle, i_clk, i_rst_n, o_cmd_pop, r_state != S_IDLE, "command popped but sequencer stayed idle")

endmodule
`default_nettype wire

// ===== sv/frame_bitmap_region_marker.sv =====
// Opcode 3 or an empty region passes from the command queue to the result register;
// a region walk reads and rewrites one 8-frame map word per cycle through the single
// read-modify-write port of the map RAM, then drains the last write before the result.
// Reset opcode: a fill sweep over all ceil(MAX_FRAMES/8) map words before the result.
// Reset: synchronous active-low; afterwards the map is swept to all used, one word
// at a time over ceil(MAX_FRAMES/8) words while the input is stalled; configuration is taken throughout.
`timescale 1ns / 1ps
`default_nettype none
module frame_bitmap_region_marker #(
    parameter int MAX_FRAMES = fbrm_pkg::MAX_FRAMES_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [fbrm_pkg::COUNT_W-1:0] i_cfg_wdata,
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire logic [fbrm_pkg::OP_W-1:0]    i_opcode,
    input  wire logic [fbrm_pkg::ADDR_W-1:0]  i_start_address,
    input  wire logic [fbrm_pkg::ADDR_W-1:0]  i_region_length,
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output logic [fbrm_pkg::COUNT_W-1:0]      o_free_count,
    output logic [fbrm_pkg::COUNT_W-1:0]      o_used_count
);
    import fbrm_pkg::*;

    logic [COUNT_W-1:0] r_total_frame_count;
    t_cmd               front_cmd, q_cmd;
    logic               q_full, q_valid, q_pop, q_push, init_busy;

    // Hold the frame count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total_frame_count <= COUNT_W'(65536);
        end else if (i_cfg_we) begin
            r_total_frame_count <= i_cfg_wdata;
        end
    end

    // Accept a transfer when the queue has room and the map is swept
    assign o_in_stall = q_full || init_busy;
    assign q_push     = i_in_valid && !o_in_stall;

    fbrm_front #(
        .MAX_FRAMES (MAX_FRAMES)
    ) u_front (
        .i_opcode            (i_opcode),
        .i_start_address     (i_start_address),
        .i_region_length     (i_region_length),
        .i_total_frame_count (r_total_frame_count),
        .o_cmd               (front_cmd)
    );

    fbrm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (front_cmd),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    fbrm_back #(
        .MAX_FRAMES (MAX_FRAMES)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (q_valid),
        .i_cmd        (q_cmd),
        .o_cmd_pop    (q_pop),
        .o_init_busy  (init_busy),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_free_count (o_free_count),
        .o_used_count (o_used_count)
    );

endmodule
`default_nettype wire

// ===== tb/frame_bitmap_region_marker_tb.sv =====
// Self-checking testbench for the frame bitmap region marker: used/free counts per request.
`timescale 1ns / 1ps
module frame_bitmap_region_marker_tb;
    import fbrm_pkg::*;

    localparam logic [OP_W-1:0] OP_NOP      = 2'd3;
    localparam int unsigned     CYCLE_LIMIT = 60_000_000;
    localparam int              HOLD_CYCLES = 600;
    localparam int              SEG_ITEMS   = 233;

    typedef struct packed {
        logic [COUNT_W-1:0] free_count;
        logic [COUNT_W-1:0] used_count;
    } t_count_pair;

    // Frame map mirror plus the queue of counts the block should report
    class frame_tally_board;
        bit                 frame_used [MAX_FRAMES_DEF];
        logic [COUNT_W-1:0] frame_limit;
        logic [COUNT_W-1:0] used_tally;
        logic [COUNT_W-1:0] free_tally;
        t_count_pair        expected_counts [$];
        int unsigned        fail_count;
        int unsigned        results_seen;

        function new();
            foreach (frame_used[f]) frame_used[f] = 1'b1;
            frame_limit  = COUNT_W'(MAX_FRAMES_DEF);
            used_tally   = COUNT_W'(MAX_FRAMES_DEF);
            free_tally   = '0;
            fail_count   = 0;
            results_seen = 0;
        endfunction

        function int unsigned managed_frames();
            return (frame_limit > MAX_FRAMES_DEF) ? MAX_FRAMES_DEF : int'(frame_limit);
        endfunction

        function logic [COUNT_W-1:0] bump_count(logic [COUNT_W-1:0] value);
            return (value == COUNT_MAX) ? value : value + 1'b1;
        endfunction

        function logic [COUNT_W-1:0] drop_count(logic [COUNT_W-1:0] value);
            return (value == '0) ? value : value - 1'b1;
        endfunction

        // Flip frames in [first, last) below the frame limit; count only real changes
        function void walk_frames(int unsigned first, int unsigned last, bit to_used);
            int unsigned lim;
            lim = managed_frames();
            for (int unsigned f = first; f < last && f < lim; f++) begin
                if (frame_used[f] != to_used) begin
                    frame_used[f] = to_used;
                    if (to_used) begin
                        used_tally = bump_count(used_tally);
                        free_tally = drop_count(free_tally);
                    end else begin
                        free_tally = bump_count(free_tally);
                        used_tally = drop_count(used_tally);
                    end
                end
            end
        endfunction

        function void apply_request(logic [OP_W-1:0] op, logic [ADDR_W-1:0] start,
                                    logic [ADDR_W-1:0] len);
            logic [ADDR_W-1:0] end_byte;
            logic [ADDR_W-1:0] first_byte;
            logic [ADDR_W-1:0] last_byte;
            t_count_pair       counts;
            end_byte = start + len;
            case (op)
                OP_RESET: begin
                    foreach (frame_used[f]) frame_used[f] = 1'b1;
                    used_tally = COUNT_W'(managed_frames());
                    free_tally = '0;
                end
                OP_MARK_USED: begin
                    // widen to whole frames; the end wraps modulo 2^32
                    first_byte = start & ~PAGE_MASK;
                    last_byte  = (end_byte + PAGE_MASK) & ~PAGE_MASK;
                    walk_frames(first_byte >> PAGE_SHIFT, last_byte >> PAGE_SHIFT, 1'b1);
                end
                OP_MARK_FREE: begin
                    // narrow to whole frames; an empty region leaves the map alone
                    first_byte = (start + PAGE_MASK) & ~PAGE_MASK;
                    last_byte  = end_byte & ~PAGE_MASK;
                    if (last_byte > first_byte)
                        walk_frames(first_byte >> PAGE_SHIFT, last_byte >> PAGE_SHIFT, 1'b0);
                end
                default: ;
            endcase
            counts.free_count = free_tally;
            counts.used_count = used_tally;
            expected_counts.push_back(counts);
        endfunction

        function void check_counts(logic [COUNT_W-1:0] free, logic [COUNT_W-1:0] used);
            t_count_pair want;
            results_seen++;
            if (expected_counts.size() == 0) begin
                $display("%0t: result with no request pending: free %0d, used %0d",
                         $time, free, used);
                fail_count++;
                return;
            end
            want = expected_counts.pop_front();
            if (free !== want.free_count) begin
                $display("%0t: free_count mismatch: expected %0d, actual %0d",
                         $time, want.free_count, free);
                fail_count++;
            end
            if (used !== want.used_count) begin
                $display("%0t: used_count mismatch: expected %0d, actual %0d",
                         $time, want.used_count, used);
                fail_count++;
            end
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n         = 1'b0;
    logic                 i_cfg_we        = 1'b0;
    logic [COUNT_W-1:0]   i_cfg_wdata     = '0;
    logic                 i_in_valid      = 1'b0;
    logic                 o_in_stall;
    logic [OP_W-1:0]      i_opcode        = '0;
    logic [ADDR_W-1:0]    i_start_address = '0;
    logic [ADDR_W-1:0]    i_region_length = '0;
    logic                 o_out_valid;
    logic                 i_out_stall     = 1'b0;
    logic [COUNT_W-1:0]   o_free_count;
    logic [COUNT_W-1:0]   o_used_count;

    frame_tally_board board = new();
    int          tx_idle_pct   = 38;
    int          rx_idle_pct   = 88;
    bit          hold_toggle   = 1'b0;
    bit          hold_seen     = 1'b0;
    int          hold_left     = 0;
    int unsigned cycle_count   = 0;
    int unsigned requests_sent = 0;
    int unsigned directed_sent = 0;

    frame_bitmap_region_marker i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_opcode       (i_opcode),
        .i_start_address(i_start_address),
        .i_region_length(i_region_length),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_free_count   (o_free_count),
        .o_used_count   (o_used_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     board.expected_counts.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Drive the result stall: a long hold when requested, random otherwise
    always @(posedge i_clk) begin
        if (hold_toggle != hold_seen) begin
            hold_seen   <= hold_toggle;
            hold_left   <= HOLD_CYCLES - 1;
            i_out_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
        end
    end

    // Check every result transfer
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            board.check_counts(o_free_count, o_used_count);
    end

    // Offer one request, hold it until the transfer, then maybe idle
    task automatic send_request(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] start,
                                input logic [ADDR_W-1:0] len);
        i_in_valid      <= 1'b1;
        i_opcode        <= op;
        i_start_address <= start;
        i_region_length <= len;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        board.apply_request(op, start, len);
        requests_sent++;
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(0, 99) < tx_idle_pct) @(posedge i_clk);
        end
    endtask

    // Stop offering and wait for every outstanding result
    task automatic drain_block();
        i_in_valid <= 1'b0;
        while (board.expected_counts.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_total(input logic [COUNT_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        board.frame_limit = value;
    endtask

    // Set the frame limit on an idle block, then send random requests
    task automatic run_segment(input int count, input logic [COUNT_W-1:0] total,
                               input bit open_with_reset, input int hold_at);
        logic [OP_W-1:0]   op;
        logic [ADDR_W-1:0] start;
        logic [ADDR_W-1:0] len;
        int unsigned       span;
        int unsigned       pick;
        drain_block();
        write_total(total);
        if (open_with_reset) send_request(OP_RESET, $urandom(), $urandom());
        span = board.managed_frames() + 16;
        for (int n = 0; n < count; n++) begin
            if (n == hold_at) hold_toggle <= ~hold_toggle;
            pick = $urandom_range(0, 199);
            if (pick < 3)        op = OP_RESET;
            else if (pick < 13)  op = OP_NOP;
            else if (pick < 106) op = OP_MARK_USED;
            else                 op = OP_MARK_FREE;
            // mostly near the managed frames, some anywhere, some near the top
            pick = $urandom_range(0, 99);
            if (pick < 70)
                start = ($urandom_range(0, span - 1) << PAGE_SHIFT) |
                        ($urandom_range(0, 1) ? $urandom_range(0, 4095) : 0);
            else if (pick < 85)
                start = $urandom();
            else
                start = 32'hFFFF_0000 | $urandom_range(0, 32'hFFFF);
            // keep most regions short; long walks are slow
            pick = $urandom_range(0, 99);
            if (pick < 78)      len = $urandom_range(0, 20 * 4096);
            else if (pick < 95) len = $urandom_range(0, 512 * 4096);
            else if (pick < 98) len = $urandom_range(0, 32'h1000_0000);
            else                len = $urandom();
            send_request(op, start, len);
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_total(COUNT_W'(MAX_FRAMES_DEF));

        // Directed: alignment edges, wraps, empty regions, limits, every opcode
        send_request(OP_NOP,       32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(OP_MARK_FREE, 32'h0000_0000, 32'h0001_0000);
        send_request(OP_MARK_FREE, 32'h0000_1001, 32'h0000_1FFF);
        send_request(OP_MARK_FREE, 32'h0000_5001, 32'h0000_0800);
        send_request(OP_MARK_USED, 32'h0000_0FFF, 32'h0000_0001);
        send_request(OP_MARK_USED, 32'h0000_3000, 32'h0000_0000);
        send_request(OP_MARK_USED, 32'h0000_3001, 32'h0000_0000);
        send_request(OP_MARK_FREE, 32'hFFFF_FFFF, 32'h0000_3000);
        send_request(OP_MARK_USED, 32'hFFFF_F000, 32'h0000_2000);
        send_request(OP_MARK_USED, 32'h0000_0000, 32'hFFFF_FFFF);
        send_request(OP_MARK_FREE, 32'hFFFF_FFFF, 32'h0000_0000);
        send_request(OP_MARK_USED, 32'h0FFF_F000, 32'h0000_1000);
        send_request(OP_MARK_USED, 32'h1000_0000, 32'h0000_1000);
        send_request(OP_MARK_FREE, 32'h0FFF_F000, 32'hF000_1000);
        send_request(OP_MARK_USED, 32'h0000_0000, 32'h1000_0000);
        send_request(OP_MARK_FREE, 32'h0080_0000, 32'h0000_5000);
        send_request(OP_RESET,     32'hFFFF_FFFF, 32'h0000_0000);
        send_request(OP_NOP,       32'h0000_0000, 32'h0000_0000);
        directed_sent = requests_sent;

        // Sender idles little, receiver a lot
        run_segment(SEG_ITEMS, 17'd1000, 1'b0, -1);
        run_segment(SEG_ITEMS, 17'd0, 1'b1, -1);

        // Swap the idling
        drain_block();
        tx_idle_pct = 88;
        rx_idle_pct <= 38;
        run_segment(SEG_ITEMS, COUNT_MAX, 1'b0, -1);
        run_segment(SEG_ITEMS, 17'd1, 1'b0, -1);

        // No idling; one long receiver hold while requests keep coming
        drain_block();
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
        run_segment(SEG_ITEMS, COUNT_W'(MAX_FRAMES_DEF), 1'b0, 40);
        run_segment(SEG_ITEMS, COUNT_W'($urandom_range(8, 65535)), 1'b1, -1);

        drain_block();
        repeat (20) @(posedge i_clk);
        if (board.expected_counts.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time,
                     board.expected_counts.size());
            board.fail_count++;
        end
        $display("Sent %0d requests (%0d directed), checked %0d results", requests_sent,
                 directed_sent, board.results_seen);
        $display("Frame limits 0, 1, 1000, 65536, 131071 and one random, three idle mixes");
        if (board.fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+sv
sv/fbrm_pkg.sv
sv/fbrm_ram.sv
sv/fbrm_front.sv
sv/fbrm_queue.sv
sv/fbrm_back.sv
sv/frame_bitmap_region_marker.sv
tb/frame_bitmap_region_marker_tb.sv
